// ===== rtl/shs_pkg.sv =====
package shs_pkg;

    localparam int unsigned WordW     = 32;
    localparam int unsigned NumVars   = 8;
    localparam int unsigned SchedDepth = 16;
    localparam int unsigned NumRounds = 64;
    localparam logic [7:0]  PadMark   = 8'h80;
    localparam logic [5:0]  LenPos    = 6'd56;

    typedef logic [WordW-1:0] t_word;
    typedef t_word t_vars [NumVars];

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_out;

    localparam t_word InitH [NumVars] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word big_s0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_s1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_s0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_s1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

// ===== rtl/shs_ram.sv =====
module shs_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr0,
    input  logic [$clog2(Depth)-1:0] i_raddr1,
    output logic [Width-1:0]         o_rdata0,
    output logic [Width-1:0]         o_rdata1
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end

endmodule

// ===== rtl/shs_round.sv =====
module shs_round (
    input  shs_pkg::t_vars i_vars,
    input  shs_pkg::t_word i_w,
    input  shs_pkg::t_word i_k,
    output shs_pkg::t_vars o_vars
);

    shs_pkg::t_word t1;
    shs_pkg::t_word t2;

    always_comb begin
        t1 = i_vars[7] + shs_pkg::big_s1(i_vars[4])
           + ((i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6])) + i_k + i_w;
        t2 = shs_pkg::big_s0(i_vars[0])
           + ((i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2]) ^ (i_vars[1] & i_vars[2]));
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

endmodule

// ===== rtl/sha256_stream_hasher.sv =====
// sha-256 over a byte stream. one byte beat per cycle is taken while the block
// collects a 64-byte block; a beat with last_byte ends the message (it may carry
// no byte, so an empty message works). the input stalls while a block is being
// compressed, while padding is appended and while the digest goes out. after
// its 64 byte beats a full block is compressed: each of the 64 rounds takes a
// read state and a compute and write-back state, as the message schedule lives
// in a 16-word memory with registered reads; one more state finishes the last
// round and one adds into the chain value. finishing a message appends up to
// 64 pad bytes at one per cycle (up to 72 when the length spills into an extra
// block), each full block again being compressed, then eight digest beats
// h0..h7. afterwards the block starts the next message on its own.
module sha256_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  shs_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output shs_pkg::t_out o_data
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;  // taking byte beats
    localparam logic [2:0] S_PAD  = 3'd1;  // appending pad and length bytes
    localparam logic [2:0] S_RD   = 3'd2;  // issue schedule reads, finish previous round
    localparam logic [2:0] S_WC   = 3'd3;  // schedule word, write back
    localparam logic [2:0] S_LAST = 3'd4;  // finish round 63
    localparam logic [2:0] S_ADD  = 3'd5;  // fold into chain value
    localparam logic [2:0] S_OUT  = 3'd6;  // digest beats

    localparam int unsigned AddrW = $clog2(shs_pkg::SchedDepth);

    // control state
    logic [2:0]  r_state, n_state;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_len, n_len;
    logic        r_mark, n_mark;         // 0x80 already appended
    logic        r_wrap_need, n_wrap_need; // mark landed inside length slot
    logic        r_pad, n_pad;           // padding pending after this block
    logic        r_done, n_done;         // final length byte pushed
    logic [5:0]  r_rnd, n_rnd;
    logic [2:0]  r_oidx, n_oidx;
    shs_pkg::t_vars r_chain, n_chain;

    // datapath registers
    logic [23:0]    r_word, n_word;
    shs_pkg::t_word r_w, n_w;
    shs_pkg::t_vars r_vars, n_vars;

    // byte push path
    logic       push_en;
    logic [7:0] push_byte;
    logic       len_phase;
    logic [63:0] bit_len;
    logic [2:0]  len_sel;

    // schedule memory ports
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr;
    shs_pkg::t_word   ram_wdata;
    logic [AddrW-1:0] addr_w2, addr_w7, addr_w15, addr_w16;
    shs_pkg::t_word   rd_w2, rd_w7, rd_w15, rd_w16;
    shs_pkg::t_word   sched_w;

    // round unit
    logic [5:0]     k_idx;
    shs_pkg::t_vars rnd_out;

    // two copies of the schedule give four reads per round
    assign addr_w2  = r_rnd[AddrW-1:0] - AddrW'(2);
    assign addr_w7  = r_rnd[AddrW-1:0] - AddrW'(7);
    assign addr_w15 = r_rnd[AddrW-1:0] - AddrW'(15);
    assign addr_w16 = r_rnd[AddrW-1:0];

    shs_ram #(
        .Width(shs_pkg::WordW),
        .Depth(shs_pkg::SchedDepth)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr0(addr_w2),
        .i_raddr1(addr_w7),
        .o_rdata0(rd_w2),
        .o_rdata1(rd_w7)
    );

    shs_ram #(
        .Width(shs_pkg::WordW),
        .Depth(shs_pkg::SchedDepth)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr0(addr_w15),
        .i_raddr1(addr_w16),
        .o_rdata0(rd_w15),
        .o_rdata1(rd_w16)
    );

    // first 16 rounds use message words as stored
    assign sched_w = (r_rnd[5:4] == 2'b00) ? rd_w16
                   : shs_pkg::small_s1(rd_w2) + rd_w7 + shs_pkg::small_s0(rd_w15) + rd_w16;

    assign k_idx = (r_state == S_LAST) ? r_rnd : r_rnd - 6'd1;

    shs_round u_round (
        .i_vars(r_vars),
        .i_w   (r_w),
        .i_k   (shs_pkg::RoundK[k_idx]),
        .o_vars(rnd_out)
    );

    // padding byte selection
    assign bit_len   = {r_len[60:0], 3'b000};
    assign len_phase = r_mark && !r_wrap_need && (r_fill >= shs_pkg::LenPos);
    assign len_sel   = 3'd7 - r_fill[2:0];
    assign o_stall   = (r_state != S_IDLE);

    always_comb begin
        push_en   = 1'b0;
        push_byte = i_data.data_byte;
        if (r_state == S_IDLE) begin
            push_en = i_valid && i_data.has_byte;
        end else if (r_state == S_PAD) begin
            push_en = 1'b1;
            if (!r_mark) begin
                push_byte = shs_pkg::PadMark;
            end else if (len_phase) begin
                push_byte = bit_len[{len_sel, 3'b000} +: 8];
            end else begin
                push_byte = 8'h00;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_len       = r_len;
        n_mark      = r_mark;
        n_wrap_need = r_wrap_need;
        n_pad       = r_pad;
        n_done      = r_done;
        n_rnd       = r_rnd;
        n_oidx      = r_oidx;
        n_chain     = r_chain;
        n_word      = r_word;
        n_w         = r_w;
        n_vars      = r_vars;
        ram_we      = 1'b0;
        ram_waddr   = r_fill[5:2];
        ram_wdata   = {r_word, push_byte};

        // bytes pack big-endian into schedule words
        if (push_en) begin
            n_word = {r_word[15:0], push_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'b11) begin
                ram_we = 1'b1;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_data.has_byte) begin
                        n_len = r_len + 64'd1;
                    end
                    if (i_data.last_byte) begin
                        n_pad   = 1'b1;
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (!r_mark) begin
                    n_mark      = 1'b1;
                    n_wrap_need = (r_fill >= shs_pkg::LenPos);
                end
                if (len_phase && (r_fill == 6'd63)) begin
                    n_done = 1'b1;
                end
            end
            S_RD: begin
                if (r_rnd != 6'd0) begin
                    n_vars = rnd_out;
                end
                n_state = S_WC;
            end
            S_WC: begin
                n_w = sched_w;
                if (r_rnd[5:4] != 2'b00) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rnd[AddrW-1:0];
                    ram_wdata = sched_w;
                end
                if (r_rnd == 6'd63) begin
                    n_state = S_LAST;
                end else begin
                    n_rnd   = r_rnd + 6'd1;
                    n_state = S_RD;
                end
            end
            S_LAST: begin
                n_vars  = rnd_out;
                n_state = S_ADD;
            end
            S_ADD: begin
                for (int j = 0; j < shs_pkg::NumVars; j++) begin
                    n_chain[j] = r_chain[j] + r_vars[j];
                end
                if (r_done) begin
                    n_state = S_OUT;
                end else if (r_pad) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_oidx == 3'd7) begin
                        n_oidx  = 3'd0;
                        n_chain = shs_pkg::InitH;
                        n_len   = 64'd0;
                        n_fill  = 6'd0;
                        n_mark  = 1'b0;
                        n_pad   = 1'b0;
                        n_done  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a full block starts compression, overriding the byte states
        if (push_en && (r_fill == 6'd63)) begin
            n_vars      = r_chain;
            n_rnd       = 6'd0;
            n_wrap_need = 1'b0;
            n_state     = S_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_len       <= 64'd0;
            r_mark      <= 1'b0;
            r_wrap_need <= 1'b0;
            r_pad       <= 1'b0;
            r_done      <= 1'b0;
            r_rnd       <= 6'd0;
            r_oidx      <= 3'd0;
            r_chain     <= shs_pkg::InitH;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_len       <= n_len;
            r_mark      <= n_mark;
            r_wrap_need <= n_wrap_need;
            r_pad       <= n_pad;
            r_done      <= n_done;
            r_rnd       <= n_rnd;
            r_oidx      <= n_oidx;
            r_chain     <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_w    <= n_w;
        r_vars <= n_vars;
    end

    // digest beats come straight from the chain registers
    assign o_valid             = (r_state == S_OUT);
    assign o_data.digest_word  = r_chain[r_oidx];
    assign o_data.word_index   = r_oidx;
    assign o_data.last_word    = (r_oidx == 3'd7);

endmodule

// ===== rtl/shs_checker.sv =====
module shs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_stall,
    input logic          o_valid,
    input logic          i_stall,
    input shs_pkg::t_out o_data
);

    // digest beats count up without gaps
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_data.last_word
        |=> o_valid && (o_data.word_index == $past(o_data.word_index) + 3'd1))
        else $error("digest index did not advance");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_word == (o_data.word_index == 3'd7)))
        else $error("last_word mismatch");

    // no byte beat taken while a digest is going out
    a_no_input_during_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during digest");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled digest beat changed");

endmodule

bind sha256_stream_hasher shs_checker u_shs_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_data (o_data)
);

// ===== tb/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

    // digest bookkeeping: running sha-256 of the message in flight, queue of digest beats
    class digest_board;
        shs_pkg::t_word chain [8];
        bit [7:0]       buf_bytes [64];
        int             fill;
        bit [63:0]      msg_len;
        shs_pkg::t_out  pending [$];
        int             errors;
        int             digests;

        function void restart();
            foreach (chain[i]) chain[i] = shs_pkg::InitH[i];
            fill = 0;
            msg_len = 0;
        endfunction

        function shs_pkg::t_word rotr(shs_pkg::t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            shs_pkg::t_word w [64];
            shs_pkg::t_word v [8];
            shs_pkg::t_word t1, t2;
            for (int i = 0; i < 16; i++)
                w[i] = {buf_bytes[4*i], buf_bytes[4*i+1], buf_bytes[4*i+2], buf_bytes[4*i+3]};
            for (int i = 16; i < 64; i++)
                w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            v = chain;
            for (int i = 0; i < 64; i++) begin
                t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::RoundK[i] + w[i];
                t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            foreach (chain[i]) chain[i] += v[i];
        endfunction

        function void append(bit [7:0] b);
            buf_bytes[fill] = b;
            fill = (fill + 1) % 64;
            if (fill == 0) compress();
        endfunction

        function void note_input(shs_pkg::t_in beat);
            bit [63:0] bits;
            shs_pkg::t_out r;
            if (beat.has_byte) begin
                msg_len++;
                append(beat.data_byte);
            end
            if (!beat.last_byte) return;
            bits = msg_len << 3;
            append(shs_pkg::PadMark);
            while (fill != shs_pkg::LenPos) append(8'h00);
            for (int i = 0; i < 8; i++) append(bits[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                r.digest_word = chain[i];
                r.word_index = i[2:0];
                r.last_word = (i == 7);
                pending.push_back(r);
            end
            digests++;
            restart();
        endfunction

        function void check_result(shs_pkg::t_out got);
            shs_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $error("digest beat with nothing pending: %h", got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.digest_word !== exp_r.digest_word) begin
                $error("digest_word exp %h got %h", exp_r.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== exp_r.word_index) begin
                $error("word_index exp %0d got %0d", exp_r.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== exp_r.last_word) begin
                $error("last_word exp %0d got %0d", exp_r.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    shs_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall = 1'b0;
    shs_pkg::t_out o_data;

    digest_board board;
    int    idle_pct;            // chance of an idle cycle, zero during the steady stretch
    int    quiet_cycles = 0;    // cycles since the last accepted beat
    int    sent_beats;
    bit    timed_out;

    localparam int WatchLimit = 20000;

    sha256_stream_hasher i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // output side: sample on rising edge, random stall driven on falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_data);
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < idle_pct);
    end

    // watchdog: nothing accepted for too long ends the run
    always @(posedge i_clk) begin
        if (quiet_cycles >= WatchLimit) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // send one beat, holding it until the block takes it
    task automatic send_beat(bit [7:0] b, bit has, bit last);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_data <= '{data_byte: b, has_byte: has, last_byte: last};
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_input('{data_byte: b, has_byte: has, last_byte: last});
        sent_beats++;
        @(negedge i_clk);
    endtask

    // message of n bytes, random content, last flag on its final byte or on an empty beat
    task automatic send_message(int n, bit tail_empty);
        for (int i = 0; i < n; i++)
            send_beat(8'($urandom_range(255)), 1'b1, (i == n - 1) && !tail_empty);
        if (tail_empty || n == 0) send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    initial begin
        board = new();
        board.restart();
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;
        idle_pct = 0;
        sent_beats = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, byte extremes, a no-op beat, short messages
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5a, 1'b0, 1'b0);
        send_beat(8'hff, 1'b1, 1'b1);
        send_beat(8'haa, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'h00, 1'b0, 1'b1);
        send_message(2, 1'b0);
        send_message(3, 1'b1);

        // steady stretch with no idling, length forces an extra pad block
        send_message(56, 1'b0);

        // random messages with idling on both sides
        idle_pct = 7;
        send_message(55, 1'b1);
        while (sent_beats < 130) begin
            case ($urandom_range(3))
                0: send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                1: send_message($urandom_range(1, 12), 1'($urandom_range(1)));
                default: send_message($urandom_range(0, 8), 1'($urandom_range(1)));
            endcase
        end
        i_valid <= 1'b0;

        // drain the digest beats, then a short tail
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("sent %0d input beats covering %0d messages", sent_beats, board.digests);
        $display("including empty, padding-boundary and two-block messages");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/shs_pkg.sv
rtl/shs_ram.sv
rtl/shs_round.sv
rtl/sha256_stream_hasher.sv
rtl/shs_checker.sv
tb/sha256_stream_hasher_tb.sv
